/* rtl/core/grm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and coefficient lookup for the grid ray marcher.
package grm_pkg;

  // Default configuration of the top level
  localparam int DEF_MAX_STEPS  = 255;
  localparam int DEF_MAP_DIM    = 64;
  localparam int DEF_ANGLE_BITS = 12;

  // Fixed-point constants
  localparam int          ONE_Q16        = 65536;
  localparam int          POS_W          = 24;      // signed ray position, Q16
  localparam logic [15:0] STEP_LEN_RESET = 16'd6554;
  localparam logic [3:0]  WALL_CODE      = 4'd1;
  localparam logic [3:0]  SEEN_CODE      = 4'd8;
  localparam logic [22:0] DIST_MAX       = 23'h7FFFFF;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CAST  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Highest-order Q30 coefficient of the quarter-wave sine polynomial
  localparam logic [30:0] SIN_COEF_TOP = 31'd172272;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [3:0]  cell_value;
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [11:0] ray_angle;
  } item_t;

  typedef struct packed {
    logic [22:0] distance;
    logic        hit_wall;
    logic [3:0]  read_value;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CELL_WR,
    ST_CELL_RD,
    ST_CELL_CAP,
    ST_MUL_UU,
    ST_LOAD_U2,
    ST_MUL_U2T,
    ST_HORNER,
    ST_MUL_UT,
    ST_ROUND,
    ST_MUL_SC,
    ST_SET_DX,
    ST_MUL_SS,
    ST_SET_DY,
    ST_MARCH_FIRST,
    ST_MARCH,
    ST_DIST_ABS,
    ST_DIST_SUM,
    ST_FIN
  } st_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CELL_WR,
    OP_CELL_RD,
    OP_CELL_CAP,
    OP_MUL_UU,
    OP_LOAD_U2,
    OP_MUL_U2T,
    OP_HORNER,
    OP_MUL_UT,
    OP_ROUND,
    OP_MUL_SC,
    OP_SET_DX,
    OP_MUL_SS,
    OP_SET_DY,
    OP_MARCH_FIRST,
    OP_MARCH,
    OP_DIST_ABS,
    OP_DIST_SUM,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       side;      // 0: sine of u, 1: sine of one minus u
    logic [1:0] coef_idx;  // Horner coefficient for this step
    logic       advance;   // march: take the next step
  } dp_cmd_t;

  // Q30 coefficients of sin(pi/2 * u), orders 1, 3, 5, 7
  function automatic logic [30:0] sin_coef(input logic [1:0] idx);
    logic [30:0] c;
    case (idx)
      2'd0:    c = 31'd1686629713;
      2'd1:    c = 31'd693598668;
      2'd2:    c = 31'd85569306;
      default: c = 31'd5026995;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/grm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module grm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/grm_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences commands, trig evaluation and the march.
module grm_ctrl #(
  parameter int MAX_STEPS = grm_pkg::DEF_MAX_STEPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_cmd,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  input  logic             wall,
  output grm_pkg::dp_cmd_t cmd
);

  import grm_pkg::*;

  localparam int SCW = $clog2(MAX_STEPS + 2);
  localparam logic [SCW-1:0] LAST_STEP = SCW'(MAX_STEPS + 1);

  st_t            state;
  st_t            state_next;
  logic           side;
  logic [1:0]     horner_idx;
  logic [SCW-1:0] step_cnt;
  logic           last_step;
  logic           march_done;
  logic           can_load;

  assign last_step  = (step_cnt == LAST_STEP);
  assign march_done = wall || last_step;
  assign can_load   = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item_cmd)
            CMD_WRITE: state_next = ST_CELL_WR;
            CMD_READ:  state_next = ST_CELL_RD;
            CMD_CAST:  state_next = ST_MUL_UU;
            CMD_NOP:   state_next = ST_FIN;
            default:   state_next = ST_FIN;
          endcase
        end
      end
      ST_CELL_WR:     state_next = ST_FIN;
      ST_CELL_RD:     state_next = ST_CELL_CAP;
      ST_CELL_CAP:    state_next = ST_FIN;
      ST_MUL_UU:      state_next = ST_LOAD_U2;
      ST_LOAD_U2:     state_next = ST_MUL_U2T;
      ST_MUL_U2T:     state_next = ST_HORNER;
      ST_HORNER:      state_next = (horner_idx == 2'd0) ? ST_MUL_UT : ST_MUL_U2T;
      ST_MUL_UT:      state_next = ST_ROUND;
      ST_ROUND:       state_next = side ? ST_MUL_SC : ST_MUL_UU;
      ST_MUL_SC:      state_next = ST_SET_DX;
      ST_SET_DX:      state_next = ST_MUL_SS;
      ST_MUL_SS:      state_next = ST_SET_DY;
      ST_SET_DY:      state_next = ST_MARCH_FIRST;
      ST_MARCH_FIRST: state_next = ST_MARCH;
      ST_MARCH:       state_next = march_done ? ST_DIST_ABS : ST_MARCH;
      ST_DIST_ABS:    state_next = ST_DIST_SUM;
      ST_DIST_SUM:    state_next = ST_FIN;
      ST_FIN:         state_next = can_load ? ST_IDLE : ST_FIN;
      default:        state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.side     = side;
    cmd.coef_idx = horner_idx;
    item_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:        cmd.op = item_valid ? OP_LATCH : OP_NONE;
      ST_CELL_WR:     cmd.op = OP_CELL_WR;
      ST_CELL_RD:     cmd.op = OP_CELL_RD;
      ST_CELL_CAP:    cmd.op = OP_CELL_CAP;
      ST_MUL_UU:      cmd.op = OP_MUL_UU;
      ST_LOAD_U2:     cmd.op = OP_LOAD_U2;
      ST_MUL_U2T:     cmd.op = OP_MUL_U2T;
      ST_HORNER:      cmd.op = OP_HORNER;
      ST_MUL_UT:      cmd.op = OP_MUL_UT;
      ST_ROUND:       cmd.op = OP_ROUND;
      ST_MUL_SC:      cmd.op = OP_MUL_SC;
      ST_SET_DX:      cmd.op = OP_SET_DX;
      ST_MUL_SS:      cmd.op = OP_MUL_SS;
      ST_SET_DY:      cmd.op = OP_SET_DY;
      ST_MARCH_FIRST: cmd.op = OP_MARCH_FIRST;
      ST_MARCH: begin
        cmd.op      = OP_MARCH;
        cmd.advance = !march_done;
      end
      ST_DIST_ABS:    cmd.op = OP_DIST_ABS;
      ST_DIST_SUM:    cmd.op = OP_DIST_SUM;
      ST_FIN:         cmd.op = can_load ? OP_LOAD_OUT : OP_NONE;
      default:        cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      side         <= 1'b0;
      horner_idx   <= 2'd0;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        side <= 1'b0;
      end else if (state == ST_ROUND) begin
        side <= 1'b1;
      end
      if (state == ST_LOAD_U2) begin
        horner_idx <= 2'd3;
      end else if (state == ST_HORNER) begin
        horner_idx <= horner_idx - 2'd1;
      end
      if (state == ST_MARCH_FIRST) begin
        step_cnt <= SCW'(1);
      end else if (state == ST_MARCH && !march_done) begin
        step_cnt <= step_cnt + SCW'(1);
      end
      if (cmd.op == OP_LOAD_OUT) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARCH) |-> (step_cnt != '0 && step_cnt <= LAST_STEP))
    else $error("march step count out of range");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && result_valid && result_stall) |=> (state == ST_FIN && result_valid))
    else $error("result overwritten while stalled");

endmodule

/* rtl/core/grm_datapath.sv */
`timescale 1ns / 1ps
// Datapath: item and config registers, shared multiplier, march logic, map RAM.
module grm_datapath #(
  parameter int MAP_DIM    = grm_pkg::DEF_MAP_DIM,
  parameter int ANGLE_BITS = grm_pkg::DEF_ANGLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  grm_pkg::item_t   item,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  grm_pkg::dp_cmd_t cmd,
  output logic             wall,
  output grm_pkg::result_t result
);

  import grm_pkg::*;

  localparam int AW = $clog2(MAP_DIM * MAP_DIM);
  localparam int RW = $clog2(MAP_DIM);
  localparam logic [15:0]      ANG_MASK = 16'((32'd1 << ANGLE_BITS) - 32'd1);
  localparam logic [6:0]       DIM7     = 7'(MAP_DIM);
  localparam logic [POS_W-1:0] LIMIT    = POS_W'(MAP_DIM * ONE_Q16);

  item_t            item_r;
  logic [15:0]      step_length;
  logic [63:0]      prod;
  logic [30:0]      u2;
  logic [30:0]      t;
  logic [16:0]      sine_a;
  logic [16:0]      sine_b;
  logic [POS_W-1:0] dx, dy, x, y;
  logic             oob_r;
  logic             fwd_r;
  logic [AW-1:0]    addr_r;
  logic             hit_r;
  logic [22:0]      dist_r;
  logic [3:0]       read_value_r;
  logic [22:0]      ax, ay;

  // trig operands
  logic [15:0] phase;
  logic [1:0]  quad;
  logic [16:0] u;
  logic [16:0] ucur;
  logic [16:0] c_mag, s_mag;
  logic        c_neg, dy_neg;
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [48:0] rsum;
  logic [18:0] rval;
  logic [32:0] vsum;
  logic [16:0] vstep;

  // cell access
  logic          in_map;
  logic [AW-1:0] cell_addr;

  // march
  logic [POS_W-1:0] base_x, base_y, nx, ny;
  logic             n_oob;
  logic [AW-1:0]    n_addr;
  logic [3:0]       cell_now;
  logic [POS_W-1:0] diff_x, diff_y;
  logic [23:0]      dsum;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [3:0]    ram_wdata, ram_rdata;

  assign phase  = (({4'b0, item_r.ray_angle}) & ANG_MASK) << (16 - ANGLE_BITS);
  assign quad   = phase[15:14];
  assign u      = {1'b0, phase[13:0], 2'b00};
  assign ucur   = cmd.side ? (17'(ONE_Q16) - u) : u;
  assign c_mag  = quad[0] ? sine_a : sine_b;
  assign s_mag  = quad[0] ? sine_b : sine_a;
  assign c_neg  = quad[1] ^ quad[0];
  assign dy_neg = !quad[1];
  assign rsum   = prod[48:0] + 49'd536870912;
  assign rval   = rsum[48:30];
  assign vsum   = {1'b0, prod[31:0]} + 33'd32768;
  assign vstep  = vsum[32:16];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MUL_UU: begin
        mul_a = 32'(ucur);
        mul_b = 32'(ucur);
      end
      OP_MUL_U2T: begin
        mul_a = 32'(u2);
        mul_b = 32'(t);
      end
      OP_MUL_UT: begin
        mul_a = 32'(ucur);
        mul_b = 32'(t);
      end
      OP_MUL_SC: begin
        mul_a = 32'(step_length);
        mul_b = 32'(c_mag);
      end
      OP_MUL_SS: begin
        mul_a = 32'(step_length);
        mul_b = 32'(s_mag);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign in_map    = ({1'b0, item_r.cell_row} < DIM7) && ({1'b0, item_r.cell_col} < DIM7);
  assign cell_addr = AW'(AW'(item_r.cell_row) * AW'(MAP_DIM) + AW'(item_r.cell_col));

  // step from the player on the first march cycle, else from the pending position
  assign base_x = (cmd.op == OP_MARCH_FIRST) ? POS_W'(item_r.pos_x) : x;
  assign base_y = (cmd.op == OP_MARCH_FIRST) ? POS_W'(item_r.pos_y) : y;
  assign nx     = base_x + dx;
  assign ny     = base_y + dy;
  // negative positions are huge as unsigned, so one compare covers both edges
  assign n_oob  = (nx >= LIMIT) || (ny >= LIMIT);
  assign n_addr = AW'(AW'(ny[16 +: RW]) * AW'(MAP_DIM) + AW'(nx[16 +: RW]));

  // the cell written last cycle is still old in RAM
  assign cell_now = fwd_r ? SEEN_CODE : ram_rdata;
  assign wall     = oob_r || (cell_now == WALL_CODE);

  assign diff_x = x - POS_W'(item_r.pos_x);
  assign diff_y = y - POS_W'(item_r.pos_y);
  assign dsum   = {1'b0, ax} + {1'b0, ay};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = item_r.cell_value;
    ram_re    = 1'b0;
    ram_raddr = cell_addr;
    case (cmd.op)
      OP_CELL_WR: ram_we = in_map;
      OP_CELL_RD: ram_re = 1'b1;
      OP_MARCH_FIRST: begin
        ram_re    = 1'b1;
        ram_raddr = n_addr;
      end
      OP_MARCH: begin
        ram_we    = !wall;
        ram_waddr = addr_r;
        ram_wdata = SEEN_CODE;
        ram_re    = cmd.advance;
        ram_raddr = n_addr;
      end
      default: ram_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_LEN_RESET;
    end else if (cfg_we) begin
      step_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    case (cmd.op)
      OP_LATCH: begin
        item_r       <= item;
        hit_r        <= 1'b0;
        dist_r       <= '0;
        read_value_r <= '0;
      end
      OP_CELL_CAP: read_value_r <= in_map ? ram_rdata : 4'd0;
      OP_LOAD_U2: begin
        u2 <= prod[32:2];
        t  <= SIN_COEF_TOP;
      end
      OP_HORNER: t <= 31'(32'(sin_coef(cmd.coef_idx)) - prod[61:30]);
      OP_ROUND: begin
        if (cmd.side) begin
          sine_b <= (rval > 19'd65536) ? 17'(ONE_Q16) : rval[16:0];
        end else begin
          sine_a <= (rval > 19'd65536) ? 17'(ONE_Q16) : rval[16:0];
        end
      end
      OP_SET_DX: dx <= c_neg ? (POS_W'(0) - POS_W'(vstep)) : POS_W'(vstep);
      OP_SET_DY: dy <= dy_neg ? (POS_W'(0) - POS_W'(vstep)) : POS_W'(vstep);
      OP_MARCH_FIRST: begin
        x      <= nx;
        y      <= ny;
        oob_r  <= n_oob;
        addr_r <= n_addr;
        fwd_r  <= 1'b0;
      end
      OP_MARCH: begin
        hit_r <= wall;
        if (cmd.advance) begin
          x      <= nx;
          y      <= ny;
          oob_r  <= n_oob;
          addr_r <= n_addr;
          fwd_r  <= (n_addr == addr_r);
        end
      end
      OP_DIST_ABS: begin
        ax <= diff_x[POS_W-1] ? 23'(POS_W'(0) - diff_x) : diff_x[22:0];
        ay <= diff_y[POS_W-1] ? 23'(POS_W'(0) - diff_y) : diff_y[22:0];
      end
      OP_DIST_SUM: dist_r <= dsum[23] ? DIST_MAX : dsum[22:0];
      OP_LOAD_OUT: begin
        result.distance   <= dist_r;
        result.hit_wall   <= hit_r;
        result.read_value <= read_value_r;
      end
      default: ;
    endcase
  end

  grm_ram #(
    .WIDTH(4),
    .DEPTH(MAP_DIM * MAP_DIM)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_advance_not_wall: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MARCH && cmd.advance) |-> !wall)
    else $error("march advanced past a wall");

  a_no_mark_outside: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MARCH && ram_we) |-> !oob_r)
    else $error("cell marked for a position outside the map");

endmodule

/* rtl/core/grid_ray_march_distance.sv */
`timescale 1ns / 1ps
// Top level of the grid ray marcher: controller, datapath and config port.
// A cast marches N steps (1 .. MAX_STEPS+1), one step per cycle on the map RAM.
// Throughput: one transaction at a time; the next is taken the cycle after the
//   result enters the output register, even while that result is still stalled.
// Reset (rst, synchronous): controller idle, no result pending, step_length 6554.
//   The map RAM is not cleared; cells are undefined until written.
module grid_ray_march_distance #(
  parameter int MAX_STEPS  = grm_pkg::DEF_MAX_STEPS,
  parameter int MAP_DIM    = grm_pkg::DEF_MAP_DIM,
  parameter int ANGLE_BITS = grm_pkg::DEF_ANGLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  // input transactions
  input  logic             item_valid,
  output logic             item_stall,
  input  grm_pkg::item_t   item,
  // result transactions
  output logic             result_valid,
  input  logic             result_stall,
  output grm_pkg::result_t result,
  // step_length register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  import grm_pkg::*;

  dp_cmd_t dp_cmd;
  logic    wall;

  // the user must write step_length only while idle; the block does not enforce it, so the write is always taken
  assign cfg_ready = 1'b1;

  // Controller: IDLE takes a transaction, then walks the command's sequence: a
  // cell write or read, or for a cast two quarter-wave sines (Horner on one shared
  // 32x32 multiplier), step scaling, the march loop (one cell read + mark per
  // cycle) and distance, or none for a NOP; each hands off to the output register.
  grm_ctrl #(
    .MAX_STEPS(MAX_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_cmd    (item.command),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .wall        (wall),
    .cmd         (dp_cmd)
  );

  // Datapath: latched transaction, multiplier, ray position with forwarding
  // of the cell marked in the previous step, and the map RAM.
  grm_datapath #(
    .MAP_DIM   (MAP_DIM),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .cmd     (dp_cmd),
    .wall    (wall),
    .result  (result)
  );

endmodule
